>>> hw/rtl/spss_pkg.sv
// ----------------------------------------------------------------------------
// spss_pkg
// Shared types and defaults for the sorted pair sum search block.
// ----------------------------------------------------------------------------
package spss_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    typedef struct packed {
        logic bank;
        logic dropped;
    } job_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_FETCH,
        ST_CMP,
        ST_DONE
    } srch_state_t;

endpackage

>>> hw/rtl/sorted_pair_sum_search.sv
// ----------------------------------------------------------------------------
// sorted_pair_sum_search
// Loads a list of signed elements and reports whether two distinct positions
// sum to the target given with the final element.
// ----------------------------------------------------------------------------
// Elements load one per cycle into one of two list buffers, so a new list
// loads while the previous one is searched or its result waits. The search
// reads the shared element memory through a single registered read port,
// so each compare waits in a fetch state for the element it needs. Input
// stalls only while both buffers hold lists not yet finished. Elements
// beyond DEPTH are dropped and the result reports overflow.
// ----------------------------------------------------------------------------
module sorted_pair_sum_search #(
    parameter int DEPTH      = spss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = spss_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic signed [DATA_WIDTH-1:0] target,
    input  logic                         last,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         found,
    output logic                         overflow
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                         q_full, q_empty, push, pop;
    spss_pkg::job_ctl_t           push_ctl, head_ctl;
    logic [CNT_W-1:0]             push_count, head_count;
    logic signed [DATA_WIDTH-1:0] push_target, head_target;
    logic                         mem_wr_en;
    logic [IDX_W:0]               mem_wr_addr;
    logic signed [DATA_WIDTH-1:0] mem_wr_data;

    spss_front #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .value       (value),
        .target      (target),
        .last        (last),
        .q_full      (q_full),
        .push        (push),
        .push_ctl    (push_ctl),
        .push_count  (push_count),
        .push_target (push_target),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    spss_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_ctl    (push_ctl),
        .push_count  (push_count),
        .push_target (push_target),
        .pop         (pop),
        .full        (q_full),
        .empty       (q_empty),
        .head_ctl    (head_ctl),
        .head_count  (head_count),
        .head_target (head_target)
    );

    spss_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .q_empty      (q_empty),
        .head_ctl     (head_ctl),
        .head_count   (head_count),
        .head_target  (head_target),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .found        (found),
        .overflow     (overflow)
    );

endmodule

>>> hw/rtl/spss_front.sv
// ----------------------------------------------------------------------------
// spss_front
// Accepts list elements, writes them into the free list buffer and posts a
// search job when the final element of a list arrives.
// ----------------------------------------------------------------------------
module spss_front #(
    parameter int DEPTH      = spss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = spss_pkg::DATA_WIDTH_DEF,
    localparam int IDX_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic signed [DATA_WIDTH-1:0] target,
    input  logic                         last,
    input  logic                         q_full,
    output logic                         push,
    output spss_pkg::job_ctl_t           push_ctl,
    output logic [CNT_W-1:0]             push_count,
    output logic signed [DATA_WIDTH-1:0] push_target,
    output logic                         mem_wr_en,
    output logic [IDX_W:0]               mem_wr_addr,
    output logic signed [DATA_WIDTH-1:0] mem_wr_data
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             bank_reg, bank_next;
    logic             accept;
    logic             room;
    logic [CNT_W-1:0] count_upd;
    logic             dropped_upd;

    assign item_ready  = !q_full;
    assign accept      = item_valid && !q_full;
    assign room        = count_reg < CNT_W'(DEPTH);
    assign count_upd   = room ? count_reg + CNT_W'(1) : count_reg;
    assign dropped_upd = dropped_reg || !room;

    assign mem_wr_en   = accept && room;
    assign mem_wr_addr = {bank_reg, count_reg[IDX_W-1:0]};
    assign mem_wr_data = value;

    assign push             = accept && last;
    assign push_ctl.bank    = bank_reg;
    assign push_ctl.dropped = dropped_upd;
    assign push_count       = count_upd;
    assign push_target      = target;

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        bank_next    = bank_reg;
        if (accept)
        begin
            if (last)
            begin
                count_next   = '0;
                dropped_next = 1'b0;
                bank_next    = !bank_reg;
            end
            else
            begin
                count_next   = count_upd;
                dropped_next = dropped_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            bank_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            bank_reg    <= bank_next;
        end
    end

endmodule

>>> hw/rtl/spss_queue.sv
// ----------------------------------------------------------------------------
// spss_queue
// Two-entry job queue between the loader and the search engine; one entry
// per list buffer.
// ----------------------------------------------------------------------------
module spss_queue #(
    parameter int DEPTH      = spss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = spss_pkg::DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  spss_pkg::job_ctl_t           push_ctl,
    input  logic [CNT_W-1:0]             push_count,
    input  logic signed [DATA_WIDTH-1:0] push_target,
    input  logic                         pop,
    output logic                         full,
    output logic                         empty,
    output spss_pkg::job_ctl_t           head_ctl,
    output logic [CNT_W-1:0]             head_count,
    output logic signed [DATA_WIDTH-1:0] head_target
);

    spss_pkg::job_ctl_t           ctl_q [2];
    logic [CNT_W-1:0]             cnt_q [2];
    logic signed [DATA_WIDTH-1:0] tgt_q [2];
    logic                         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                   fill_reg, fill_next;
    logic                         do_push, do_pop;

    assign full    = fill_reg == 2'd2;
    assign empty   = fill_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign head_ctl    = ctl_q[rd_ptr_reg];
    assign head_count  = cnt_q[rd_ptr_reg];
    assign head_target = tgt_q[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctl_q[wr_ptr_reg] <= push_ctl;
            cnt_q[wr_ptr_reg] <= push_count;
            tgt_q[wr_ptr_reg] <= push_target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

>>> hw/rtl/spss_back.sv
// ----------------------------------------------------------------------------
// spss_back
// Holds the two list buffers and runs the two-pointer search on the job at
// the head of the queue, one pointer move per compare.
// ----------------------------------------------------------------------------
module spss_back #(
    parameter int DEPTH      = spss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = spss_pkg::DATA_WIDTH_DEF,
    localparam int IDX_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         mem_wr_en,
    input  logic [IDX_W:0]               mem_wr_addr,
    input  logic signed [DATA_WIDTH-1:0] mem_wr_data,
    input  logic                         q_empty,
    input  spss_pkg::job_ctl_t           head_ctl,
    input  logic [CNT_W-1:0]             head_count,
    input  logic signed [DATA_WIDTH-1:0] head_target,
    output logic                         pop,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         found,
    output logic                         overflow
);

    logic signed [DATA_WIDTH-1:0] mem [2**(IDX_W+1)];

    spss_pkg::srch_state_t        state_reg, state_next;
    logic [IDX_W-1:0]             lo_reg, lo_next;
    logic [IDX_W-1:0]             hi_reg, hi_next;
    logic signed [DATA_WIDTH-1:0] lo_val_reg, lo_val_next;
    logic signed [DATA_WIDTH-1:0] hi_val_reg, hi_val_next;
    logic                         fetch_hi_reg, fetch_hi_next;
    logic                         hit_reg, hit_next;
    logic signed [DATA_WIDTH-1:0] rd_data_reg;
    logic [IDX_W:0]               rd_addr;
    logic                         out_valid_reg, out_valid_next;
    logic                         found_reg, found_next;
    logic                         overflow_reg, overflow_next;

    logic signed [DATA_WIDTH:0]   sum;
    logic signed [DATA_WIDTH:0]   tgt_ext;
    logic                         sum_eq, sum_lt;
    logic [IDX_W-1:0]             lo_inc, hi_dec;
    logic                         lo_meet, hi_meet;
    logic                         short_list;
    logic                         out_free;

    assign sum        = {lo_val_reg[DATA_WIDTH-1], lo_val_reg}
                      + {hi_val_reg[DATA_WIDTH-1], hi_val_reg};
    assign tgt_ext    = {head_target[DATA_WIDTH-1], head_target};
    assign sum_eq     = sum == tgt_ext;
    assign sum_lt     = sum < tgt_ext;
    assign lo_inc     = lo_reg + IDX_W'(1);
    assign hi_dec     = hi_reg - IDX_W'(1);
    assign lo_meet    = lo_inc == hi_reg;
    assign hi_meet    = hi_dec == lo_reg;
    assign short_list = head_count < CNT_W'(2);
    assign out_free   = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign found        = found_reg;
    assign overflow     = overflow_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spss_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = short_list ? spss_pkg::ST_DONE : spss_pkg::ST_INIT;
                end
            end
            spss_pkg::ST_INIT:
            begin
                state_next = spss_pkg::ST_FETCH;
            end
            spss_pkg::ST_FETCH:
            begin
                state_next = spss_pkg::ST_CMP;
            end
            spss_pkg::ST_CMP:
            begin
                if (sum_eq || (sum_lt && lo_meet) || (!sum_lt && hi_meet))
                begin
                    state_next = spss_pkg::ST_DONE;
                end
                else
                begin
                    state_next = spss_pkg::ST_FETCH;
                end
            end
            spss_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = spss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        lo_val_next    = lo_val_reg;
        hi_val_next    = hi_val_reg;
        fetch_hi_next  = fetch_hi_reg;
        hit_next       = hit_reg;
        rd_addr        = {head_ctl.bank, lo_reg};
        pop            = 1'b0;
        found_next     = found_reg;
        overflow_next  = overflow_reg;
        out_valid_next = out_valid_reg && !result_ready;
        unique case (state_reg)
            spss_pkg::ST_IDLE:
            begin
                hit_next = 1'b0;
                lo_next  = '0;
                hi_next  = IDX_W'(head_count - CNT_W'(1));
                rd_addr  = {head_ctl.bank, {IDX_W{1'b0}}};
            end
            spss_pkg::ST_INIT:
            begin
                lo_val_next   = rd_data_reg;
                fetch_hi_next = 1'b1;
                rd_addr       = {head_ctl.bank, hi_reg};
            end
            spss_pkg::ST_FETCH:
            begin
                if (fetch_hi_reg)
                begin
                    hi_val_next = rd_data_reg;
                end
                else
                begin
                    lo_val_next = rd_data_reg;
                end
            end
            spss_pkg::ST_CMP:
            begin
                if (sum_eq)
                begin
                    hit_next = 1'b1;
                end
                else if (sum_lt)
                begin
                    lo_next       = lo_inc;
                    fetch_hi_next = 1'b0;
                    rd_addr       = {head_ctl.bank, lo_inc};
                end
                else
                begin
                    hi_next       = hi_dec;
                    fetch_hi_next = 1'b1;
                    rd_addr       = {head_ctl.bank, hi_dec};
                end
            end
            spss_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    pop            = 1'b1;
                    found_next     = hit_reg;
                    overflow_next  = head_ctl.dropped;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        lo_val_reg   <= lo_val_next;
        hi_val_reg   <= hi_val_next;
        found_reg    <= found_next;
        overflow_reg <= overflow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spss_pkg::ST_IDLE;
            lo_reg        <= '0;
            hi_reg        <= '0;
            fetch_hi_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            fetch_hi_reg  <= fetch_hi_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
